// File: design/qgap_pkg.sv
// Shared types, constants and helpers of the quantized global average pool.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package qgap_pkg;

    localparam int LANES        = 8;
    localparam int MAX_CHANNELS = 512;
    localparam int BYTE_W       = 8;
    localparam int GROUP_W      = 6;
    localparam int ACC_W        = 32;
    localparam int SHIFT_W      = 6;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_IDX_W    = 3;

    // One memory row holds the accumulators of one group of lanes.
    localparam int ROWS  = MAX_CHANNELS / LANES;
    localparam int ROW_W = $clog2(ROWS);

    // Stages between acceptance and the output queue: memory read, accumulate,
    // multiply, decrement and shift; the final saturation is combinational.
    localparam int PIPE_STAGES = 5;
    localparam int OUTQ_DEPTH  = 8;
    localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W  = $clog2(OUTQ_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIAS       = 3'd0,
        CFG_SCALE_MULT = 3'd1,
        CFG_RIGHT_SHFT = 3'd2,
        CFG_ZERO_POINT = 3'd3,
        CFG_CLAMP_LOW  = 3'd4,
        CFG_CLAMP_HIGH = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0]  lane0;
        logic [BYTE_W-1:0]  lane1;
        logic [BYTE_W-1:0]  lane2;
        logic [BYTE_W-1:0]  lane3;
        logic [BYTE_W-1:0]  lane4;
        logic [BYTE_W-1:0]  lane5;
        logic [BYTE_W-1:0]  lane6;
        logic [BYTE_W-1:0]  lane7;
        logic [GROUP_W-1:0] group;
        logic               first_row;
        logic               last_row;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0]  out0;
        logic [BYTE_W-1:0]  out1;
        logic [BYTE_W-1:0]  out2;
        logic [BYTE_W-1:0]  out3;
        logic [BYTE_W-1:0]  out4;
        logic [BYTE_W-1:0]  out5;
        logic [BYTE_W-1:0]  out6;
        logic [BYTE_W-1:0]  out7;
        logic [GROUP_W-1:0] out_group;
    } t_out_item;

    typedef logic [LANES-1:0][BYTE_W-1:0] t_byte_vec;
    typedef logic [LANES-1:0][ACC_W-1:0]  t_acc_vec;

    // Requantization settings shared by all lanes.
    typedef struct packed {
        logic signed [ACC_W-1:0] scale_mult;
        logic [SHIFT_W-1:0]      right_shift;
        logic [BYTE_W-1:0]       zero_point;
        logic [BYTE_W-1:0]       clamp_low;
        logic [BYTE_W-1:0]       clamp_high;
    } t_rq_cfg;

    function automatic t_byte_vec get_lanes(input t_in_item x);
        t_byte_vec v;
        v[0] = x.lane0;
        v[1] = x.lane1;
        v[2] = x.lane2;
        v[3] = x.lane3;
        v[4] = x.lane4;
        v[5] = x.lane5;
        v[6] = x.lane6;
        v[7] = x.lane7;
        return v;
    endfunction

    function automatic t_out_item make_out(input t_byte_vec b, input logic [GROUP_W-1:0] g);
        t_out_item o;
        o.out0      = b[0];
        o.out1      = b[1];
        o.out2      = b[2];
        o.out3      = b[3];
        o.out4      = b[4];
        o.out5      = b[5];
        o.out6      = b[6];
        o.out7      = b[7];
        o.out_group = g;
        return o;
    endfunction

endpackage

`default_nettype wire

// File: design/qgap_accum.sv
// Accumulator stage: one 32-bit sum memory per lane, read-modify-write with a bypass
// for back-to-back items on the same group. Depends on qgap_pkg.
`default_nettype none

module qgap_accum
    import qgap_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_acc,
    input  wire t_byte_vec            i_vals,
    input  wire logic [ROW_W-1:0]     i_row,
    input  wire logic                 i_first,
    input  wire logic [ACC_W-1:0]     i_bias,
    output t_acc_vec                  o_sum
);

    logic             r_a_vld;
    logic [ROW_W-1:0] r_a_row;
    logic             r_a_first;
    t_byte_vec        r_a_vals;
    logic             r_a_byp;
    t_acc_vec         r_a_bsum;
    t_acc_vec         r_a_rdata;
    t_acc_vec         n_sum;
    t_acc_vec         r_b_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_a_byp <= 1'b0;
        end else begin
            r_a_vld <= i_acc;
            // The item in this stage writes its row at the same edge at which
            // the new item reads it, so the new item takes the sum directly.
            r_a_byp <= i_acc && r_a_vld && (r_a_row == i_row);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_a_row   <= i_row;
            r_a_first <= i_first;
            r_a_vals  <= i_vals;
        end
        r_a_bsum <= n_sum;
        r_b_sum  <= n_sum;
    end

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        logic [ACC_W-1:0] r_mem [ROWS];
        logic [ACC_W-1:0] base;

        always_ff @(posedge i_clk) begin
            r_a_rdata[k] <= r_mem[i_row];
            if (r_a_vld) begin
                r_mem[r_a_row] <= n_sum[k];
            end
        end

        always_comb begin
            if (r_a_first) begin
                base = i_bias;
            end else if (r_a_byp) begin
                base = r_a_bsum[k];
            end else begin
                base = r_a_rdata[k];
            end
            n_sum[k] = base + {{(ACC_W-BYTE_W){1'b0}}, r_a_vals[k]};
        end
    end

    assign o_sum = r_b_sum;

endmodule

`default_nettype wire

// File: design/qgap_rq_lane.sv
// One requantization lane: multiply, negative correction, rounding shift and
// saturation down to a clamped byte. Depends on qgap_pkg.
`default_nettype none

module qgap_rq_lane
    import qgap_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic [ACC_W-1:0]  i_sum,
    input  wire t_rq_cfg           i_cfg,
    output logic [BYTE_W-1:0]      o_byte
);

    logic signed [2*ACC_W-1:0] r_c_prod;
    logic                      r_c_neg;
    logic signed [2*ACC_W-1:0] r_d_p;
    logic [ACC_W-1:0]          r_e_lo;
    logic                      r_e_half;

    logic signed [2*ACC_W-1:0] q;
    logic                      half;
    logic signed [ACC_W-1:0]   v;
    logic signed [15:0]        s16;
    logic signed [16:0]        w;
    logic [BYTE_W-1:0]         b;

    always_comb begin
        if (i_cfg.right_shift != '0) begin
            q    = r_d_p >>> i_cfg.right_shift;
            half = r_d_p[i_cfg.right_shift - SHIFT_W'(1)];
        end else begin
            q    = r_d_p;
            half = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_prod <= $signed(i_sum) * i_cfg.scale_mult;
        r_c_neg  <= i_sum[ACC_W-1];
        r_d_p    <= r_c_prod - {{(2*ACC_W-1){1'b0}}, r_c_neg};
        // Only the low word of the shifted value is kept, so the rounding
        // increment is added after truncation.
        r_e_lo   <= q[ACC_W-1:0];
        r_e_half <= half;
    end

    always_comb begin
        v = $signed(r_e_lo + {{(ACC_W-1){1'b0}}, r_e_half});
        if (v > 32'sd32767) begin
            s16 = 16'sh7fff;
        end else if (v < -32'sd32768) begin
            s16 = 16'sh8000;
        end else begin
            s16 = v[15:0];
        end
        w = {s16[15], s16} + $signed({9'b0, i_cfg.zero_point});
        if (w[16]) begin
            b = '0;
        end else if (w > 17'sd255) begin
            b = 8'hff;
        end else begin
            b = w[BYTE_W-1:0];
        end
        if (b < i_cfg.clamp_low) begin
            b = i_cfg.clamp_low;
        end
        if (b > i_cfg.clamp_high) begin
            b = i_cfg.clamp_high;
        end
        o_byte = b;
    end

endmodule

`default_nettype wire

// File: design/qgap_outq.sv
// Output queue that merges the lane bytes and group of each result item and
// holds them until taken. Depends on qgap_pkg.
`default_nettype none

module qgap_outq
    import qgap_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire t_byte_vec             i_bytes,
    input  wire logic [GROUP_W-1:0]    i_group,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output t_out_item                  o_item,
    output logic [OUTQ_CNT_W-1:0]      o_count
);

    t_out_item              r_buf [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0]  r_wr_ptr;
    logic [OUTQ_PTR_W-1:0]  r_rd_ptr;
    logic [OUTQ_CNT_W-1:0]  r_count;
    logic                   pop;

    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + OUTQ_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + OUTQ_PTR_W'(1);
            end
            r_count <= r_count + OUTQ_CNT_W'(i_push) - OUTQ_CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= make_out(i_bytes, i_group);
        end
    end

    assign o_valid = (r_count != '0);
    assign o_item  = r_buf[r_rd_ptr];
    assign o_count = r_count;

endmodule

`default_nettype wire

// File: design/quantized_global_average_pool.sv
// Quantized global average pool over groups of eight uint8 channels. One input item
// is accepted every clock cycle while o_in_ready is high; each lane keeps its 32-bit
// sums in a 64-entry memory that is read and written back in one stage, with a bypass
// for consecutive items on the same group. A last-row item goes on to the output queue;
// the eight-entry queue and the five pipeline stages set the credit limit, so input
// ready drops only when the output side has stalled long enough to fill it.
// The sum memories are not cleared at reset: a group must start with a first row.
`default_nettype none

module quantized_global_average_pool
    import qgap_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire t_in_item               i_in_item,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output t_out_item                   o_out_item,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    logic [ACC_W-1:0]    r_bias;
    t_rq_cfg             r_rq_cfg;

    logic                in_acc;
    logic [PIPE_STAGES-1:0] r_vld;
    logic [PIPE_STAGES-1:0] r_lst;
    logic [GROUP_W-1:0]  r_grp [PIPE_STAGES];
    logic                push;
    logic [OUTQ_CNT_W-1:0] q_count;
    logic [OUTQ_CNT_W:0] load;

    t_acc_vec            sums;
    t_byte_vec           bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias               <= '0;
            r_rq_cfg.scale_mult  <= '0;
            r_rq_cfg.right_shift <= '0;
            r_rq_cfg.zero_point  <= '0;
            r_rq_cfg.clamp_low   <= '0;
            r_rq_cfg.clamp_high  <= 8'hff;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_BIAS:       r_bias               <= i_cfg_wdata[ACC_W-1:0];
                CFG_SCALE_MULT: r_rq_cfg.scale_mult  <= i_cfg_wdata[ACC_W-1:0];
                CFG_RIGHT_SHFT: r_rq_cfg.right_shift <= i_cfg_wdata[SHIFT_W-1:0];
                CFG_ZERO_POINT: r_rq_cfg.zero_point  <= i_cfg_wdata[BYTE_W-1:0];
                CFG_CLAMP_LOW:  r_rq_cfg.clamp_low   <= i_cfg_wdata[BYTE_W-1:0];
                CFG_CLAMP_HIGH: r_rq_cfg.clamp_high  <= i_cfg_wdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // Every item in the pipeline holds a queue slot until it leaves, whether
    // or not it turns into a result item.
    assign load       = {1'b0, q_count} + (OUTQ_CNT_W+1)'($countones(r_vld));
    assign o_in_ready = i_rst_n && (load < (OUTQ_CNT_W+1)'(OUTQ_DEPTH));
    assign in_acc     = i_in_valid && o_in_ready;
    assign push       = r_vld[PIPE_STAGES-1] && r_lst[PIPE_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_STAGES-2:0], in_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        r_lst    <= {r_lst[PIPE_STAGES-2:0], i_in_item.last_row};
        r_grp[0] <= i_in_item.group;
        for (int s = 1; s < PIPE_STAGES; s++) begin
            r_grp[s] <= r_grp[s-1];
        end
    end

    qgap_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (in_acc),
        .i_vals  (get_lanes(i_in_item)),
        .i_row   (i_in_item.group[ROW_W-1:0]),
        .i_first (i_in_item.first_row),
        .i_bias  (r_bias),
        .o_sum   (sums)
    );

    for (genvar k = 0; k < LANES; k++) begin : g_rq
        qgap_rq_lane u_lane (
            .i_clk  (i_clk),
            .i_sum  (sums[k]),
            .i_cfg  (r_rq_cfg),
            .o_byte (bytes[k])
        );
    end

    qgap_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_bytes (bytes),
        .i_group (r_grp[PIPE_STAGES-1]),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item),
        .o_count (q_count)
    );

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load <= (OUTQ_CNT_W+1)'(OUTQ_DEPTH))
        else $error("output queue slots overcommitted");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_item.last_row) |-> ##PIPE_STAGES push)
        else $error("last-row item did not reach the output queue");

    a_mid_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_in_item.last_row) |-> ##PIPE_STAGES !push)
        else $error("result item pushed for a row that is not the last");

endmodule

`default_nettype wire
